// ===== hdl/ndb_pkg.sv =====
// ----------------------------------------------------------------------------
// ndb_pkg
// Shared types, constants and helpers of the n-gram dictionary builder.
// ----------------------------------------------------------------------------
package ndb_pkg;

	localparam logic [7:0]  BLANK_BYTE = 8'hff;
	localparam logic [12:0] COUNT_MAX  = 13'h1fff;

	// configuration register indexes
	localparam logic [1:0] REG_GRAM_LEN    = 2'd0;
	localparam logic [1:0] REG_MAX_ENTRIES = 2'd1;
	localparam logic [1:0] REG_MIN_COUNT   = 2'd2;

	localparam int OUT_TDATA_W = 56;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_FETCH,
		ST_SCAN,
		ST_DECIDE,
		ST_EMIT,
		ST_BLANK,
		ST_FLUSH
	} state_t;

	// byte lanes that belong to a gram of g bytes, newest byte in the low lane
	function automatic logic [31:0] gram_mask(logic [2:0] g);
		logic [31:0] m;
		m = '0;
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < g) m[8*k +: 8] = 8'hff;
		end
		return m;
	endfunction

	function automatic logic gram_ok(logic [31:0] w, logic [2:0] g);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < g && w[8*k +: 8] == BLANK_BYTE) ok = 1'b0;
		end
		return ok;
	endfunction

endpackage

// ===== hdl/ndb_ram.sv =====
// ----------------------------------------------------------------------------
// ndb_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ndb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/ngram_dictionary_builder.sv =====
// ----------------------------------------------------------------------------
// ngram_dictionary_builder
// Greedy dictionary of the most frequent byte grams of a loaded buffer.
// ----------------------------------------------------------------------------
// Usage: bytes arrive on the s_ stream, one beat per cycle, into a byte RAM of
// BUF_DEPTH entries; bytes past BUF_DEPTH are dropped. The beat with s_tlast
// set ends the buffer and starts the rounds; s_tready stays low until the last
// entry has been loaded into the output register. Each round walks every
// candidate position p: it reads the gram at p and then streams the buffer from
// the start, one RAM read per cycle, counting matches, and stops early when the
// gram already occurred before p. A winning gram then costs one more pass over
// the buffer that blanks its matches in place. Each entry goes out as a beat on
// the m_ stream with m_tlast on the last one; an empty dictionary gives one
// all-zero beat with m_tlast. The output register holds a beat while m_tready
// is low and the rounds stall only when the next entry must go out.
// Reset puts the block back to loading an empty buffer with register defaults
// gram_len 3, max_entries 64, min_count 2.
// ----------------------------------------------------------------------------
module ngram_dictionary_builder
	import ndb_pkg::*;
#(
	parameter int BUF_DEPTH = 4096,
	parameter int MAX_GRAMS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_addr,
	input  logic [12:0]            cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,  // data_byte
	input  logic                   s_tlast,  // last_byte
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // gram_value, gram_count, entry_index
	output logic                   m_tlast   // final_entry
);

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int FW = AW + 1;

	state_t state_q, state_d;

	logic [2:0]  gram_len_q;
	logic [6:0]  max_entries_q;
	logic [12:0] min_count_q;

	logic [2:0]  glen_q;
	logic [6:0]  limit_q;
	logic [12:0] need_q;

	logic [FW-1:0] fill_q;
	logic [FW-1:0] p_q;
	logic [FW-1:0] rd_ptr_q;
	logic [FW-1:0] rd_idx_s1;
	logic          rd_vld_s1;
	logic [31:0]   win_q;
	logic [31:0]   key_q;
	logic [12:0]   cnt_q;
	logic [12:0]   best_cnt_q;
	logic [31:0]   best_key_q;
	logic [6:0]    entries_q;
	logic          pend_vld_q;
	logic [31:0]   pend_key_q;
	logic [12:0]   pend_cnt_q;
	logic [5:0]    pend_idx_q;
	logic          fin_q;
	logic          take_q;
	logic [3:0]    mk_q;
	logic [1:0]    skip_q;
	logic [1:0]    fl_q;
	logic [FW-1:0] ipos_q;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   m_tlast_q;

	// ram
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	// control
	logic          s_beat;
	logic          streaming;
	logic          issue;
	logic [FW-1:0] end_ptr;
	logic [31:0]   win_nx;
	logic [31:0]   gmask;
	logic          gram_hit;
	logic [FW-1:0] s_start;
	logic          idx_last;
	logic          abort;
	logic          fetch_last;
	logic          fetch_bad;
	logic          scan_last;
	logic          next_p;
	logic [FW-1:0] p_inc;
	logic          round_over;
	logic          blank_match;
	logic          blank_last;
	logic [12:0]   cnt_nx;
	logic [3:0]    mk_nx;
	logic [FW-1:0] wpos;
	logic          out_free;
	logic          ok;
	logic [3:0]    lane_bits;

	ndb_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_bytes (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_ptr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign s_tready = (state_q == ST_LOAD);
	assign s_beat   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		gmask      = gram_mask(glen_q);
		lane_bits  = {gmask[24], gmask[16], gmask[8], gmask[0]};
		streaming  = (state_q == ST_FETCH) || (state_q == ST_SCAN) || (state_q == ST_BLANK);
		end_ptr    = (state_q == ST_FETCH) ? p_q + FW'(glen_q) : fill_q;
		win_nx     = {win_q[23:0], ram_rdata};
		gram_hit   = rd_vld_s1 && (rd_idx_s1 + FW'(1) >= FW'(glen_q))
		             && ((win_nx & gmask) == key_q);
		s_start    = rd_idx_s1 + FW'(1) - FW'(glen_q);
		idx_last   = (rd_idx_s1 == fill_q - FW'(1));
		abort      = (state_q == ST_SCAN) && gram_hit && (s_start < p_q);
		fetch_last = (state_q == ST_FETCH) && rd_vld_s1
		             && (rd_idx_s1 == p_q + FW'(glen_q) - FW'(1));
		fetch_bad  = fetch_last && !gram_ok(win_nx, glen_q);
		scan_last  = (state_q == ST_SCAN) && rd_vld_s1 && !abort && idx_last;
		next_p     = fetch_bad || abort || scan_last;
		p_inc      = p_q + FW'(1);
		round_over = ({1'b0, p_inc} + (FW+1)'(glen_q)) > {1'b0, fill_q};
		cnt_nx     = (gram_hit && cnt_q != COUNT_MAX) ? cnt_q + 13'd1 : cnt_q;
		blank_match = (state_q == ST_BLANK) && gram_hit && (skip_q == 2'd0);
		blank_last  = (state_q == ST_BLANK) && rd_vld_s1 && idx_last;
		ok          = (best_cnt_q != 13'd0) && (best_cnt_q >= need_q);
		issue       = streaming && (rd_ptr_q < end_ptr) && !abort;

		// blanking marks trail the read stream by three positions
		mk_nx = mk_q;
		wpos  = ipos_q;
		if (state_q == ST_BLANK && rd_vld_s1) begin
			mk_nx = {mk_q[2:0], 1'b0} | (blank_match ? lane_bits : 4'b0000);
			wpos  = rd_idx_s1;
		end else if (state_q == ST_FLUSH) begin
			mk_nx = {mk_q[2:0], 1'b0};
			wpos  = ipos_q + FW'(1);
		end

		ram_we    = 1'b0;
		ram_waddr = fill_q[AW-1:0];
		ram_wdata = s_tdata;
		if (state_q == ST_LOAD) begin
			ram_we = s_beat && (fill_q < FW'(BUF_DEPTH));
		end else if (state_q == ST_BLANK || state_q == ST_FLUSH) begin
			ram_we    = mk_nx[3];
			ram_waddr = AW'(wpos - FW'(3));
			ram_wdata = BLANK_BYTE;
		end

		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (s_beat && s_tlast) state_d = ST_START;
			end
			ST_START: begin
				if (entries_q >= limit_q) state_d = ST_EMIT;
				else if ({1'b0, fill_q} < (FW+1)'(glen_q)) state_d = ST_DECIDE;
				else state_d = ST_FETCH;
			end
			ST_FETCH, ST_SCAN: begin
				if (next_p) state_d = round_over ? ST_DECIDE : ST_FETCH;
				else if (fetch_last) state_d = ST_SCAN;
			end
			ST_DECIDE: begin
				if (ok && !pend_vld_q) state_d = ST_BLANK;
				else state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = take_q ? ST_BLANK : ST_LOAD;
			end
			ST_BLANK: begin
				if (blank_last) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (fl_q == 2'd2) state_d = ST_START;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			gram_len_q    <= 3'd3;
			max_entries_q <= 7'd64;
			min_count_q   <= 13'd2;
			fill_q        <= '0;
			rd_vld_s1     <= 1'b0;
			entries_q     <= '0;
			pend_vld_q    <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_GRAM_LEN:    gram_len_q    <= cfg_data[2:0];
					REG_MAX_ENTRIES: max_entries_q <= cfg_data[6:0];
					REG_MIN_COUNT:   min_count_q   <= cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid_q && m_tready && !(state_q == ST_EMIT && out_free))
				m_tvalid_q <= 1'b0;
			if (state_q == ST_LOAD && s_beat) begin
				if (fill_q < FW'(BUF_DEPTH)) fill_q <= fill_q + FW'(1);
				if (s_tlast) begin
					entries_q  <= '0;
					pend_vld_q <= 1'b0;
				end
			end
			if (state_q == ST_DECIDE && ok && !pend_vld_q) begin
				pend_vld_q <= 1'b1;
				entries_q  <= entries_q + 7'd1;
			end
			if (state_q == ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
				if (take_q) begin
					entries_q <= entries_q + 7'd1;
				end else begin
					fill_q     <= '0;
					pend_vld_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_ptr_q  <= rd_ptr_q + FW'(1);
			rd_idx_s1 <= rd_ptr_q;
		end
		if (rd_vld_s1) win_q <= win_nx;

		unique case (state_q)
			ST_LOAD: begin
				if (s_beat && s_tlast) begin
					glen_q  <= (gram_len_q == 3'd0) ? 3'd1 :
					           (gram_len_q > 3'd4) ? 3'd4 : gram_len_q;
					limit_q <= (max_entries_q > 7'(MAX_GRAMS)) ? 7'(MAX_GRAMS)
					                                         : max_entries_q;
					need_q  <= (min_count_q == 13'd0) ? 13'd1 : min_count_q;
				end
			end
			ST_START: begin
				p_q        <= '0;
				rd_ptr_q   <= '0;
				best_cnt_q <= '0;
				best_key_q <= '0;
				fin_q      <= 1'b1;
				take_q     <= 1'b0;
			end
			ST_FETCH, ST_SCAN: begin
				if (fetch_last && !fetch_bad) begin
					key_q    <= win_nx & gmask;
					cnt_q    <= '0;
					rd_ptr_q <= '0;
				end
				if (state_q == ST_SCAN) cnt_q <= cnt_nx;
				if (scan_last && cnt_nx >= best_cnt_q) begin
					best_cnt_q <= cnt_nx;
					best_key_q <= key_q;
				end
				if (next_p) begin
					p_q      <= p_inc;
					rd_ptr_q <= p_inc;
				end
			end
			ST_DECIDE: begin
				fin_q  <= !ok;
				take_q <= ok;
				if (ok && !pend_vld_q) begin
					pend_key_q <= best_key_q;
					pend_cnt_q <= best_cnt_q;
					pend_idx_q <= entries_q[5:0];
					key_q      <= best_key_q;
					rd_ptr_q   <= '0;
					mk_q       <= '0;
					skip_q     <= '0;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					m_tdata_q <= {5'b0,
					              pend_vld_q ? pend_idx_q : 6'd0,
					              pend_vld_q ? pend_cnt_q : 13'd0,
					              pend_vld_q ? pend_key_q : 32'd0};
					m_tlast_q <= fin_q;
					if (take_q) begin
						pend_key_q <= best_key_q;
						pend_cnt_q <= best_cnt_q;
						pend_idx_q <= entries_q[5:0];
						key_q      <= best_key_q;
						rd_ptr_q   <= '0;
						mk_q       <= '0;
						skip_q     <= '0;
					end
				end
			end
			ST_BLANK: begin
				mk_q <= mk_nx;
				if (rd_vld_s1) begin
					// matches may not overlap: skip the next gram_len-1 end positions
					if (blank_match) skip_q <= 2'(glen_q - 3'd1);
					else if (skip_q != 2'd0) skip_q <= skip_q - 2'd1;
				end
				if (blank_last) begin
					ipos_q <= rd_idx_s1;
					fl_q   <= '0;
				end
			end
			ST_FLUSH: begin
				mk_q   <= mk_nx;
				ipos_q <= wpos;
				fl_q   <= fl_q + 2'd1;
			end
			default: ;
		endcase
	end

endmodule
